// File: rtl/mrat_pkg.sv
`default_nettype none

package mrat_pkg;

  // Default table depth and fixed field widths.
  localparam int DEF_ENTRIES = 32;
  localparam int ADDR_W      = 32;
  localparam int WIDE_W      = 64;
  localparam int COUNT_OUT_W = 6;

  // Type code that marks a region as usable memory.
  localparam logic [ADDR_W-1:0] TYPE_AVAILABLE = 32'd1;

  // Operation codes carried by in_func.
  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_BOOT_ADD = 2'd2,
    FUNC_QUERY    = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } mrat_state_t;

  // One stored region: start, exclusive end and available flag.
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic              avail;
  } region_t;

  // Accumulated hit flags of a query scan.
  typedef struct packed {
    logic avail;
    logic rsv;
  } hit_t;

endpackage

`default_nettype wire

// File: rtl/mrat_mem.sv
`default_nettype none

module mrat_mem #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire mrat_pkg::region_t wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output mrat_pkg::region_t      rd_data
);
  import mrat_pkg::*;

  region_t mem_r [DEPTH];
  region_t rd_data_r;

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/mrat_cmp.sv
`default_nettype none

module mrat_cmp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire logic              en,
  input  wire logic [31:0]       addr,
  input  wire mrat_pkg::region_t region,
  output mrat_pkg::hit_t         hits
);
  import mrat_pkg::*;

  hit_t hits_r;
  hit_t hits_nxt;
  logic in_region;

  // Shared range check: start is inclusive, end is exclusive.
  assign in_region = (addr >= region.lo) && (addr < region.hi);

  // Fold the current region into the accumulated flags.
  always_comb begin
    hits_nxt = hits_r;
    if (clr) begin
      hits_nxt = '0;
    end else if (en && in_region) begin
      if (region.avail) begin
        hits_nxt.avail = 1'b1;
      end else begin
        hits_nxt.rsv = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
    end else begin
      hits_r <= hits_nxt;
    end
  end

  assign hits = hits_r;

endmodule

`default_nettype wire

// File: rtl/memory_region_availability_table_unit.sv
`default_nettype none

// Table of up to ENTRIES memory regions with an availability lookup. Each beat on
// the input channel carries one operation: clear, add a 32-bit region, add a
// 64-bit boot region (dropped with a range status when its start or end does not
// fit in 32 bits) or query an address. Every operation returns exactly one result
// beat with a status, the query answer and the number of held regions. Clear, add,
// boot add and a query of an empty table pass through the execute and done states
// before the result is registered. A query of a non-empty table reads the held
// regions out of the region memory one per cycle through its single read port into
// one shared range comparator, then goes through the drain and done states. Once
// the result is registered the unit takes the next beat, even if the result stalls.
module memory_region_availability_table_unit #(
  parameter int ENTRIES = mrat_pkg::DEF_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_start_addr,
  input  wire logic [31:0] in_end_addr,
  input  wire logic [63:0] in_base_addr,
  input  wire logic [63:0] in_region_length,
  input  wire logic [31:0] in_region_type,
  input  wire logic [31:0] in_lookup_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_available,
  output logic [5:0]       out_entry_count
);
  import mrat_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Accepted operation.
  func_t             func_r;
  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] end_r;
  logic [WIDE_W-1:0] base_r;
  logic [WIDE_W-1:0] len_r;
  logic [ADDR_W-1:0] type_r;
  logic [ADDR_W-1:0] lookup_r;

  // Sequencer state.
  mrat_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  status_t          status_r, status_nxt;
  logic             rd_valid_r;

  // Output register.
  logic             out_valid_r;
  status_t          out_status_r;
  logic             out_available_r;
  logic [5:0]       out_entry_count_r;

  // Datapath links.
  logic              accept;
  logic              table_full;
  logic [WIDE_W-1:0] boot_stop;
  logic              boot_out_of_range;
  logic              wr_en;
  region_t           wr_data;
  logic              rd_en;
  region_t           rd_data;
  logic              cmp_clr;
  hit_t              hits;
  logic              out_load;
  logic [CNT_W+5:0]  count_ext;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Capture the operation fields of an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= func_t'(in_func);
      start_r  <= in_start_addr;
      end_r    <= in_end_addr;
      base_r   <= in_base_addr;
      len_r    <= in_region_length;
      type_r   <= in_region_type;
      lookup_r <= in_lookup_addr;
    end
  end

  // Boot regions must start and end below 4 GiB; the end wraps modulo 2^64.
  assign boot_stop         = base_r + len_r;
  assign boot_out_of_range = (|base_r[WIDE_W-1:ADDR_W]) || (|boot_stop[WIDE_W-1:ADDR_W]);
  assign table_full        = (count_r == CNT_W'(ENTRIES));

  // Sequencer: next state, table writes and scan control.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_data    = '0;
    rd_en      = 1'b0;
    cmp_clr    = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_nxt = STATUS_OK;
        state_nxt  = ST_DONE;
        unique case (func_r)
          FUNC_CLEAR: begin
            count_nxt = '0;
          end
          FUNC_ADD: begin
            wr_data.lo    = start_r;
            wr_data.hi    = end_r;
            wr_data.avail = (type_r == TYPE_AVAILABLE);
            if (table_full) begin
              status_nxt = STATUS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          FUNC_BOOT_ADD: begin
            wr_data.lo    = base_r[ADDR_W-1:0];
            wr_data.hi    = boot_stop[ADDR_W-1:0];
            wr_data.avail = (type_r == TYPE_AVAILABLE);
            if (boot_out_of_range) begin
              status_nxt = STATUS_RANGE;
            end else if (table_full) begin
              status_nxt = STATUS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          FUNC_QUERY: begin
            cmp_clr = 1'b1;
            idx_nxt = '0;
            if (count_r != '0) begin
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        // One region read per cycle; the comparator folds it in the cycle after.
        rd_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      idx_r      <= '0;
      status_r   <= STATUS_OK;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      status_r   <= status_nxt;
      rd_valid_r <= rd_en;
    end
  end

  // Region memory.
  mrat_mem #(
    .DEPTH (ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Shared range comparator with hit accumulation.
  mrat_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (cmp_clr),
    .en     (rd_valid_r),
    .addr   (lookup_r),
    .region (rd_data),
    .hits   (hits)
  );

  // The reported count is the held count masked to six bits.
  assign count_ext = {{6{1'b0}}, count_r};

  // Result register; it holds while the result beat is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r      <= status_r;
      out_available_r   <= (func_r == FUNC_QUERY) && hits.avail && !hits.rsv;
      out_entry_count_r <= count_ext[5:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_available   = out_available_r;
  assign out_entry_count = out_entry_count_r;

  // An accepted beat always starts execution in the next cycle.
  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted beat did not start execution");

  // The held count never exceeds the table depth.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("region count beyond table depth");

  // A table write only happens while a free entry remains.
  a_write_room : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !table_full)
    else $error("region written into a full table");

  // Read data only reaches the comparator during a scan or its drain cycle.
  a_read_scan : assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> ((state_r == ST_SCAN) || (state_r == ST_DRAIN)))
    else $error("region read outside a query scan");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import mrat_pkg::*;

  localparam int NUM_ENTRIES  = DEF_ENTRIES;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = NUM_ENTRIES + 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_REPORTS  = 10;

  // One operation as it travels on the input channel.
  typedef struct {
    func_t       func;
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [63:0] base_addr;
    logic [63:0] region_length;
    logic [31:0] region_type;
    logic [31:0] lookup_addr;
  } table_op_t;

  // One answer as it travels on the result channel.
  typedef struct {
    status_t    status;
    logic       available;
    logic [5:0] entry_count;
  } table_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [31:0] in_start_addr = '0;
  logic [31:0] in_end_addr = '0;
  logic [63:0] in_base_addr = '0;
  logic [63:0] in_region_length = '0;
  logic [31:0] in_region_type = '0;
  logic [31:0] in_lookup_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_available;
  logic [5:0]  out_entry_count;

  // Our own copy of the region table.
  logic [31:0] model_lo [NUM_ENTRIES];
  logic [31:0] model_hi [NUM_ENTRIES];
  logic        model_avail [NUM_ENTRIES];
  int          model_count = 0;

  table_answer_t pending_answers[$];
  table_answer_t want;
  int            mismatch_count = 0;
  int            items_sent = 0;
  int            tx_gap_max = 16;
  int            rx_stall_max = 16;
  int            rx_wait_left = 0;
  int            idle_cycles = 0;
  logic          hold_on = 1'b0;
  event          hold_go;

  memory_region_availability_table_unit #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_start_addr(in_start_addr),
    .in_end_addr(in_end_addr),
    .in_base_addr(in_base_addr),
    .in_region_length(in_region_length),
    .in_region_type(in_region_type),
    .in_lookup_addr(in_lookup_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_available(out_available),
    .out_entry_count(out_entry_count)
  );

  always #2 clk = ~clk;

  // Append a region to the table copy, or report that it is full.
  function automatic status_t model_store(logic [31:0] lo, logic [31:0] hi,
                                          logic [31:0] code);
    if (model_count >= NUM_ENTRIES) return STATUS_FULL;
    model_lo[model_count]    = lo;
    model_hi[model_count]    = hi;
    model_avail[model_count] = (code == TYPE_AVAILABLE);
    model_count++;
    return STATUS_OK;
  endfunction

  // Apply one operation to the table copy and work out the answer it gives.
  function automatic table_answer_t predict_table_op(table_op_t op);
    table_answer_t res;
    logic [63:0]   stop;
    logic          hit_avail;
    logic          hit_rsv;
    int            k;
    res.status    = STATUS_OK;
    res.available = 1'b0;
    hit_avail     = 1'b0;
    hit_rsv       = 1'b0;
    stop          = op.base_addr + op.region_length;
    case (op.func)
      FUNC_CLEAR: begin
        model_count = 0;
      end
      FUNC_ADD: begin
        res.status = model_store(op.start_addr, op.end_addr, op.region_type);
      end
      FUNC_BOOT_ADD: begin
        // The range check wins over the full-table check.
        if (op.base_addr[63:32] != '0 || stop[63:32] != '0) begin
          res.status = STATUS_RANGE;
        end else begin
          res.status = model_store(op.base_addr[31:0], stop[31:0], op.region_type);
        end
      end
      default: begin
        for (k = 0; k < model_count; k++) begin
          if (op.lookup_addr >= model_lo[k] && op.lookup_addr < model_hi[k]) begin
            if (model_avail[k]) hit_avail = 1'b1;
            else hit_rsv = 1'b1;
          end
        end
        res.available = hit_avail && !hit_rsv;
      end
    endcase
    res.entry_count = 6'(model_count);
    return res;
  endfunction

  // Random content in every field; callers overwrite the fields that matter.
  function automatic table_op_t noise_op(func_t f);
    table_op_t op;
    op.func          = f;
    op.start_addr    = $urandom();
    op.end_addr      = $urandom();
    op.base_addr     = {$urandom(), $urandom()};
    op.region_length = {$urandom(), $urandom()};
    op.region_type   = $urandom();
    op.lookup_addr   = $urandom();
    return op;
  endfunction

  // Offer one beat after a random gap and record its answer once it is taken.
  task automatic send_op(table_op_t op);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= op.func;
    in_start_addr    <= op.start_addr;
    in_end_addr      <= op.end_addr;
    in_base_addr     <= op.base_addr;
    in_region_length <= op.region_length;
    in_region_type   <= op.region_type;
    in_lookup_addr   <= op.lookup_addr;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_answers.push_back(predict_table_op(op));
    items_sent++;
  endtask

  task automatic do_clear();
    send_op(noise_op(FUNC_CLEAR));
  endtask

  task automatic do_add(logic [31:0] lo, logic [31:0] hi, logic [31:0] code);
    table_op_t op;
    op             = noise_op(FUNC_ADD);
    op.start_addr  = lo;
    op.end_addr    = hi;
    op.region_type = code;
    send_op(op);
  endtask

  task automatic do_boot(logic [63:0] base, logic [63:0] len, logic [31:0] code);
    table_op_t op;
    op               = noise_op(FUNC_BOOT_ADD);
    op.base_addr     = base;
    op.region_length = len;
    op.region_type   = code;
    send_op(op);
  endtask

  task automatic do_query(logic [31:0] addr);
    table_op_t op;
    op             = noise_op(FUNC_QUERY);
    op.lookup_addr = addr;
    send_op(op);
  endtask

  // Query mostly at the edges of regions that are held right now.
  task automatic edge_query();
    logic [31:0] addr;
    int          k;
    if (model_count == 0 || $urandom_range(0, 7) == 0) begin
      addr = $urandom();
    end else begin
      k = $urandom_range(0, model_count - 1);
      case ($urandom_range(0, 4))
        0: addr = model_lo[k];
        1: addr = model_hi[k];
        2: addr = model_hi[k] - 1;
        3: addr = model_lo[k] - 1;
        default: addr = model_lo[k] + $urandom_range(0, 1023);
      endcase
    end
    do_query(addr);
  endtask

  // Result side: random stall per beat, long hold-off on request, checking.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result beat: status %0d available %0b count %0d",
                     out_status, out_available, out_entry_count);
          end
        end else begin
          want = pending_answers.pop_front();
          if (out_status !== want.status || out_available !== want.available ||
              out_entry_count !== want.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: expected status %0d available %0b count %0d, got %0d %0b %0d",
                       want.status, want.available, want.entry_count,
                       out_status, out_available, out_entry_count);
            end
          end
        end
        rx_wait_left = $urandom_range(0, rx_stall_max);
      end else if (out_valid === 1'b1 && rx_wait_left > 0) begin
        rx_wait_left--;
      end
      out_stall <= hold_on || (rx_wait_left > 0);
    end
  end

  // Long receiver hold-off, counted here once a test asks for it.
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Queries against an empty table, after reset and after clear.
  task automatic test_empty_table();
    do_query(32'h0);
    do_clear();
    do_query(32'hFFFF_FFFF);
  endtask

  // Region edges, overlap of reserved and available, empty and inverted regions.
  task automatic test_region_bounds();
    do_clear();
    do_add(32'h1000, 32'h2000, TYPE_AVAILABLE);
    do_query(32'h0FFF);
    do_query(32'h1000);
    do_query(32'h1FFF);
    do_query(32'h2000);
    do_add(32'h1800, 32'h1900, 32'd2);
    do_query(32'h1850);
    do_query(32'h1900);
    do_add(32'h3000, 32'h3000, TYPE_AVAILABLE);
    do_add(32'h5000, 32'h4000, TYPE_AVAILABLE);
    do_query(32'h3000);
    do_query(32'h4800);
    do_add(32'h0, 32'hFFFF_FFFF, TYPE_AVAILABLE);
    do_query(32'h0);
    do_query(32'hFFFF_FFFF);
    do_add(32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_query(32'hFFFF_FFFE);
    do_add(32'h8000_0000, 32'h8000_1000, 32'd0);
    do_query(32'h8000_0800);
    do_query(32'h8000_1000);
  endtask

  // Boot regions: fits, start too high, end too high, end wrapping past 2^64.
  task automatic test_boot_regions();
    do_clear();
    do_boot(64'h2000_0000, 64'h1000, TYPE_AVAILABLE);
    do_query(32'h2000_0800);
    do_boot(64'h1_0000_0000, 64'h10, TYPE_AVAILABLE);
    do_boot(64'hFFFF_F000, 64'h1000, TYPE_AVAILABLE);
    do_boot(64'hFFFF_F000, 64'hFFF, TYPE_AVAILABLE);
    do_boot('1, 64'h1, TYPE_AVAILABLE);
    do_boot(64'h10, 64'hFFFF_FFFF_FFFF_FFF0, TYPE_AVAILABLE);
    do_boot(64'h0, '1, TYPE_AVAILABLE);
    do_boot(64'h0, 64'h0, 32'd3);
    do_query(32'hFFFF_FFFE);
    do_query(32'h10);
  endtask

  // Fill every slot, then add past the end and check range before full.
  task automatic test_full_table();
    int i;
    do_clear();
    for (i = 0; i < NUM_ENTRIES; i++) begin
      do_add(i * 32'h100, i * 32'h100 + 32'h80, (i % 3 == 0) ? 32'd2 : TYPE_AVAILABLE);
    end
    do_add(32'h9000_0000, 32'h9000_1000, TYPE_AVAILABLE);
    do_boot(64'h9000_0000, 64'h1000, TYPE_AVAILABLE);
    do_boot(64'h1_9000_0000, 64'h1000, TYPE_AVAILABLE);
    do_query(32'h140);
    do_query((NUM_ENTRIES - 1) * 32'h100 + 32'h7F);
    do_clear();
    do_query(32'h140);
  endtask

  // Receiver holds off while the sender keeps offering back-to-back beats.
  task automatic test_backpressure();
    int i;
    tx_gap_max = 0;
    -> hold_go;
    for (i = 0; i < 12; i++) begin
      if (i % 2 == 0) do_add($urandom_range(0, 4095), $urandom_range(0, 8191), TYPE_AVAILABLE);
      else edge_query();
    end
    tx_gap_max = 16;
  endtask

  // Clear, build a table of random regions, and probe it; some pure noise too.
  task automatic test_random_sequences();
    int          target;
    int          adds;
    int          j;
    logic [31:0] win;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] code;
    logic [63:0] base;
    logic [63:0] len;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      // Idling regime for this sequence, including stretches with none.
      case ($urandom_range(0, 3))
        0: begin tx_gap_max = 16; rx_stall_max = 16; end
        1: begin tx_gap_max = 0;  rx_stall_max = 0;  end
        2: begin tx_gap_max = 0;  rx_stall_max = 16; end
        default: begin tx_gap_max = 16; rx_stall_max = 0; end
      endcase
      if ($urandom_range(0, 9) == 0) begin
        repeat (10) send_op(noise_op(func_t'($urandom_range(0, 3))));
      end else begin
        do_clear();
        win  = $urandom();
        adds = ($urandom_range(0, 7) == 0) ?
               $urandom_range(NUM_ENTRIES - 2, NUM_ENTRIES + 3) : $urandom_range(1, 12);
        for (j = 0; j < adds; j++) begin
          lo = win + $urandom_range(0, 4095);
          hi = lo + $urandom_range(0, 1024);
          if ($urandom_range(0, 15) == 0) hi = lo - $urandom_range(1, 64);
          if ($urandom_range(0, 19) == 0) lo = '0;
          if ($urandom_range(0, 19) == 0) hi = '1;
          case ($urandom_range(0, 3))
            0: code = 32'd2;
            1: code = $urandom();
            default: code = TYPE_AVAILABLE;
          endcase
          if ($urandom_range(0, 3) == 0) begin
            base = {32'h0, lo};
            len  = {32'h0, hi - lo};
            // Now and then push the start or the end beyond 32 bits.
            case ($urandom_range(0, 7))
              0: base[63:32] = $urandom() | 32'h1;
              1: len = {$urandom(), $urandom()};
              default: ;
            endcase
            do_boot(base, len, code);
          end else begin
            do_add(lo, hi, code);
          end
          repeat ($urandom_range(0, 2)) edge_query();
        end
        repeat (3) edge_query();
      end
    end
    tx_gap_max   = 16;
    rx_stall_max = 16;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_region_bounds();
    test_boot_regions();
    test_full_table();
    test_backpressure();
    test_random_sequences();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
